### rtl/npss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point search package
// Shared constants and register indices for the point search.
// ----------------------------------------------------------------------------
package npss_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_START_X = 2'd0;
   localparam logic [1:0] REG_START_Y = 2'd1;
   localparam logic [1:0] REG_END_X = 2'd2;
   localparam logic [1:0] REG_END_Y = 2'd3;
endpackage

### rtl/npss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Projection front end
// Computes the rounded projection of a point onto the segment with a
// restoring divider and passes the point with its squared distance on.
// ----------------------------------------------------------------------------
module npss_front #(
   parameter int CB = npss_pkg::COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [CB-1:0] sx,
   input  logic signed [CB-1:0] sy,
   input  logic signed [CB-1:0] ex,
   input  logic signed [CB-1:0] ey,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [CB-1:0] in_x,
   input  logic signed [CB-1:0] in_y,
   input  logic                 in_last,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [CB-1:0]        out_x,
   output logic [CB-1:0]        out_y,
   output logic                 out_last,
   output logic [2*CB+1:0]      out_dist
);
   import npss_pkg::*;
   localparam int DB = CB + 1;
   localparam int NB = 2 * DB + 1;
   localparam int PB = NB + DB;
   localparam int QB = DB + 1;
   localparam int CNTB = $clog2(PB + 1);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_MULX = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;
   localparam logic [2:0] ST_DIST = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;
   localparam logic [2:0] ST_RND = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [CNTB-1:0] cnt_ff, cnt_in;
   logic signed [CB-1:0] px_ff, py_ff;
   logic last_ff, ycomp_ff;
   logic signed [DB-1:0] abx_ff, aby_ff;
   logic [NB-1:0] den_ff, num_ff;
   logic [PB-1:0] prod_ff;
   logic [NB:0] rem_ff;
   logic [PB-1:0] quo_ff;
   logic signed [DB+1:0] cx_ff, cy_ff;
   logic [2*CB+1:0] dist_ff;

   logic signed [DB-1:0] abx_w, aby_w, apx_w, apy_w, off_w;
   logic signed [NB+1:0] dot_w;
   logic [NB-1:0] den_w;
   logic [DB-1:0] mag_w;
   logic [NB:0] trial_w;
   logic [QB-1:0] q_w;
   logic signed [DB+1:0] sc_w, dx_w, dy_w, base_w;
   logic [2*CB+1:0] dist_w;

   assign abx_w = DB'(ex) - DB'(sx);
   assign aby_w = DB'(ey) - DB'(sy);
   assign apx_w = DB'(in_x) - DB'(sx);
   assign apy_w = DB'(in_y) - DB'(sy);
   assign dot_w = (NB+2)'(apx_w * abx_w) + (NB+2)'(apy_w * aby_w);
   assign den_w = NB'(abx_w * abx_w) + NB'(aby_w * aby_w);
   assign off_w = ycomp_ff ? aby_ff : abx_ff;
   assign mag_w = off_w[DB-1] ? DB'(-off_w) : DB'(off_w);
   assign trial_w = {rem_ff[NB-1:0], prod_ff[PB-1]};
   assign q_w = QB'(quo_ff) + QB'(({rem_ff[NB-1:0], 1'b0}) >= {1'b0, den_ff});
   assign sc_w = off_w[DB-1] ? -(DB+2)'(q_w) : (DB+2)'(q_w);
   assign base_w = ycomp_ff ? (DB+2)'(sy) : (DB+2)'(sx);
   assign dx_w = cx_ff - (DB+2)'(px_ff);
   assign dy_w = cy_ff - (DB+2)'(py_ff);
   assign dist_w = (2*CB+2)'(dx_w * dx_w) + (2*CB+2)'(dy_w * dy_w);

   assign in_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_x = px_ff;
   assign out_y = py_ff;
   assign out_last = last_ff;
   assign out_dist = dist_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_PREP;
         ST_PREP: state_in = (den_ff == '0) ? ST_DIST : ST_MULX;
         ST_MULX: begin
            state_in = ST_DIV;
            cnt_in = CNTB'(PB);
         end
         ST_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNTB'(1)) state_in = ST_RND;
         end
         ST_RND: state_in = ycomp_ff ? ST_DIST : ST_MULX;
         ST_DIST: state_in = ST_OUT;
         ST_OUT: if (out_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      case (state_ff)
         ST_IDLE: begin
            px_ff <= in_x;
            py_ff <= in_y;
            last_ff <= in_last;
            abx_ff <= abx_w;
            aby_ff <= aby_w;
            den_ff <= den_w;
            ycomp_ff <= 1'b0;
            cx_ff <= (DB+2)'(sx);
            cy_ff <= (DB+2)'(sy);
            if (dot_w <= 0) num_ff <= '0;
            else if (dot_w > (NB+2)'(den_w)) num_ff <= den_w;
            else num_ff <= NB'(dot_w);
         end
         ST_MULX: begin
            prod_ff <= PB'(mag_w * num_ff);
            rem_ff <= '0;
            quo_ff <= '0;
         end
         ST_DIV: begin
            prod_ff <= {prod_ff[PB-2:0], 1'b0};
            if (trial_w >= {1'b0, den_ff}) begin
               rem_ff <= trial_w - {1'b0, den_ff};
               quo_ff <= {quo_ff[PB-2:0], 1'b1};
            end else begin
               rem_ff <= trial_w;
               quo_ff <= {quo_ff[PB-2:0], 1'b0};
            end
         end
         ST_RND: begin
            if (ycomp_ff) begin
               cy_ff <= base_w + sc_w;
            end else begin
               cx_ff <= base_w + sc_w;
               ycomp_ff <= 1'b1;
            end
         end
         ST_DIST: dist_ff <= dist_w;
         default: ;
      endcase
   end
endmodule

### rtl/npss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum tracker
// Keeps the nearest point of the current set and emits it on the last point.
// ----------------------------------------------------------------------------
module npss_back #(
   parameter int CB = npss_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [CB-1:0]     in_x,
   input  logic [CB-1:0]     in_y,
   input  logic              in_last,
   input  logic [2*CB+1:0]   in_dist,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CB-1:0]     out_x,
   output logic [CB-1:0]     out_y,
   output logic [2*CB:0]     out_dist
);
   import npss_pkg::*;
   logic [CB-1:0] bx_ff, by_ff;
   logic [2*CB+1:0] bd_ff;
   logic ov_ff;
   logic [CB-1:0] ox_ff, oy_ff;
   logic [2*CB:0] od_ff;
   logic take, better;
   logic [CB-1:0] nx, ny;
   logic [2*CB+1:0] nd;

   assign in_ready = !ov_ff || out_ready;
   assign take = in_valid && in_ready;
   assign better = in_dist < bd_ff;
   assign nx = better ? in_x : bx_ff;
   assign ny = better ? in_y : by_ff;
   assign nd = better ? in_dist : bd_ff;
   assign out_valid = ov_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_dist = od_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bx_ff <= '0;
         by_ff <= '0;
         bd_ff <= '1;
         ov_ff <= 1'b0;
      end else begin
         if (out_ready) ov_ff <= 1'b0;
         if (take) begin
            if (in_last) begin
               bx_ff <= '0;
               by_ff <= '0;
               bd_ff <= '1;
               ov_ff <= 1'b1;
               ox_ff <= nx;
               oy_ff <= ny;
               od_ff <= nd[2*CB:0];
            end else begin
               bx_ff <= nx;
               by_ff <= ny;
               bd_ff <= nd;
            end
         end
      end
   end
endmodule

### rtl/nearest_point_to_segment_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point to segment search
// Streams points and reports the one nearest to the configured segment.
// ----------------------------------------------------------------------------
// Points are taken one at a time: a new point is accepted only after the previous one
// has left the front end, whose shared serial divider forms the x and y projection
// offsets one quotient bit a cycle.
// Reset clears the segment registers, the running best and all valid state.
module nearest_point_to_segment_search #(
   parameter int COORD_BITS = npss_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic                   req_last_point,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_nearest_x,
   output logic signed [COORD_BITS-1:0] rsp_nearest_y,
   output logic [2*COORD_BITS:0]  rsp_nearest_dist_sq,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [npss_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import npss_pkg::*;
   logic signed [COORD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [1:0] ridx;
   logic f_valid, f_ready, f_last;
   logic [COORD_BITS-1:0] f_x, f_y;
   logic [2*COORD_BITS+1:0] f_dist;
   logic q_valid_ff, q_last_ff, q_ready;
   logic [COORD_BITS-1:0] q_x_ff, q_y_ff;
   logic [2*COORD_BITS+1:0] q_dist_ff;
   logic b_valid;

   assign pready = 1'b1;
   assign ridx = paddr[3:2];
   always_comb begin
      unique case (ridx)
         REG_START_X: prdata = 32'(sx_ff);
         REG_START_Y: prdata = 32'(sy_ff);
         REG_END_X: prdata = 32'(ex_ff);
         REG_END_Y: prdata = 32'(ey_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff <= '0;
         sy_ff <= '0;
         ex_ff <= '0;
         ey_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (ridx)
            REG_START_X: sx_ff <= pwdata[COORD_BITS-1:0];
            REG_START_Y: sy_ff <= pwdata[COORD_BITS-1:0];
            REG_END_X: ex_ff <= pwdata[COORD_BITS-1:0];
            REG_END_Y: ey_ff <= pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   npss_front #(.CB(COORD_BITS)) u_front (
      .clock(clock), .reset(reset),
      .sx(sx_ff), .sy(sy_ff), .ex(ex_ff), .ey(ey_ff),
      .in_valid(req_push), .in_ready(f_ready),
      .in_x(req_point_x), .in_y(req_point_y), .in_last(req_last_point),
      .out_valid(f_valid), .out_ready(!q_valid_ff || q_ready),
      .out_x(f_x), .out_y(f_y), .out_last(f_last), .out_dist(f_dist)
   );
   assign req_full = !f_ready || reset;

   always_ff @(posedge clock) begin
      if (reset) q_valid_ff <= 1'b0;
      else if (!q_valid_ff || q_ready) q_valid_ff <= f_valid;
      if (!q_valid_ff || q_ready) begin
         q_x_ff <= f_x;
         q_y_ff <= f_y;
         q_last_ff <= f_last;
         q_dist_ff <= f_dist;
      end
   end

   npss_back #(.CB(COORD_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid_ff), .in_ready(q_ready),
      .in_x(q_x_ff), .in_y(q_y_ff), .in_last(q_last_ff), .in_dist(q_dist_ff),
      .out_valid(b_valid), .out_ready(rsp_pop),
      .out_x(rsp_nearest_x), .out_y(rsp_nearest_y), .out_dist(rsp_nearest_dist_sq)
   );
   assign rsp_empty = !b_valid;

`ifndef ASSERT_OFF
   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !(q_valid_ff && q_last_ff) |=> rsp_empty)
      else $error("result not retired after pop");
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_nearest_x) &&
      $stable(rsp_nearest_y) && $stable(rsp_nearest_dist_sq))
      else $error("waiting result changed");
`endif
endmodule

### dv/nearest_point_to_segment_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest point to segment search testbench
// Streams point sets through the search under several segment settings, with
// random gaps on the push side and random stalls on the pop side. Each result
// transfer is checked against a bit-exact integer projection model kept here,
// or against a hand-computed value in the directed table.
// ----------------------------------------------------------------------------
module nearest_point_to_segment_search_tb;
   import npss_pkg::*;

   localparam int CB = 16;
   localparam int SETTLE_CYCLES = 150;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic [2*CB:0]        dist_sq;
   } nearest_type;

   typedef struct {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic                 last;
      logic                 typed;
      nearest_type          want;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [CB-1:0] req_point_x = '0;
   logic signed [CB-1:0] req_point_y = '0;
   logic req_last_point = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [CB-1:0] rsp_nearest_x;
   logic signed [CB-1:0] rsp_nearest_y;
   logic [2*CB:0] rsp_nearest_dist_sq;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   nearest_point_to_segment_search u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_last_point(req_last_point),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_nearest_x(rsp_nearest_x), .rsp_nearest_y(rsp_nearest_y),
      .rsp_nearest_dist_sq(rsp_nearest_dist_sq),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Segment copy and running best of the model.
   logic signed [CB-1:0] seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
   logic signed [CB-1:0] run_best_x = '0, run_best_y = '0;
   logic [2*CB+1:0] run_best_dist = '1;

   nearest_type expected_nearest[$];
   int unsigned mismatches = 0;
   bit quiet_push = 1'b0;
   bit quiet_pop = 1'b0;

   function automatic longint rounded_offset(longint offset, longint num, longint den);
      longint mag;
      longint prod;
      longint q;
      longint r;
      mag = (offset < 0) ? -offset : offset;
      prod = mag * num;
      q = prod / den;
      r = prod % den;
      if (2 * r >= den) q = q + 1;
      return (offset < 0) ? -q : q;
   endfunction

   // Folds one point into the running best; returns 1 with the result on a last point.
   function automatic bit fold_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                     logic last, output nearest_type res);
      longint abx, aby, apx, apy, den, dot, num, cx, cy, dx, dy;
      logic [2*CB+1:0] dist_val;
      abx = longint'(seg_ex) - longint'(seg_sx);
      aby = longint'(seg_ey) - longint'(seg_sy);
      apx = longint'(px) - longint'(seg_sx);
      apy = longint'(py) - longint'(seg_sy);
      den = abx * abx + aby * aby;
      dot = apx * abx + apy * aby;
      cx = seg_sx;
      cy = seg_sy;
      if (den != 0) begin
         num = (dot <= 0) ? 0 : ((dot > den) ? den : dot);
         cx = cx + rounded_offset(abx, num, den);
         cy = cy + rounded_offset(aby, num, den);
      end
      dx = cx - px;
      dy = cy - py;
      dist_val = dx * dx + dy * dy;
      if (dist_val < run_best_dist) begin
         run_best_dist = dist_val;
         run_best_x = px;
         run_best_y = py;
      end
      res = '0;
      if (!last) return 1'b0;
      res.x = run_best_x;
      res.y = run_best_y;
      res.dist_sq = run_best_dist[2*CB:0];
      run_best_x = '0;
      run_best_y = '0;
      run_best_dist = '1;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap(bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic write_reg(logic [1:0] index, logic signed [CB-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_START_X: seg_sx = value;
         REG_START_Y: seg_sy = value;
         REG_END_X: seg_ex = value;
         default: seg_ey = value;
      endcase
   endtask

   task automatic set_segment(int sx, int sy, int ex, int ey);
      wait (expected_nearest.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_START_X, sx[CB-1:0]);
      write_reg(REG_START_Y, sy[CB-1:0]);
      write_reg(REG_END_X, ex[CB-1:0]);
      write_reg(REG_END_Y, ey[CB-1:0]);
   endtask

   // Drives one point and waits for its transfer; the next call keeps push high
   // when no gap is chosen, so back-to-back points need no extra edge.
   task automatic push_point(point_row_type row);
      int unsigned gap;
      nearest_type res;
      gap = pick_gap(quiet_push);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_point_x <= row.x;
      req_point_y <= row.y;
      req_last_point <= row.last;
      do @(posedge clock); while (req_full);
      if (fold_point(row.x, row.y, row.last, res))
         expected_nearest = {expected_nearest, (row.typed ? row.want : res)};
   endtask

   function automatic point_row_type mk(int x, int y, bit last);
      point_row_type row;
      row.x = x[CB-1:0];
      row.y = y[CB-1:0];
      row.last = last;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic point_row_type mk_typed(int x, int y, int ex, int ey, longint d);
      point_row_type row;
      row = mk(x, y, 1'b1);
      row.typed = 1'b1;
      row.want.x = ex[CB-1:0];
      row.want.y = ey[CB-1:0];
      row.want.dist_sq = d[2*CB:0];
      return row;
   endfunction

   task automatic random_sets(int unsigned count, int sx, int sy, int ex, int ey);
      int unsigned n;
      int unsigned kind;
      int x;
      int y;
      point_row_type row;
      n = 0;
      while (n < count) begin
         if (n % 97 == 0) begin
            quiet_push = ($urandom_range(0, 3) == 0);
            quiet_pop = ($urandom_range(0, 3) == 0);
         end
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
         end else if (kind < 8) begin
            // Near the segment, where projections and ties are interesting.
            x = sx + ((ex - sx) * int'($urandom_range(0, 120))) / 100
                + int'($urandom_range(0, 20)) - 10;
            y = sy + ((ey - sy) * int'($urandom_range(0, 120))) / 100
                + int'($urandom_range(0, 20)) - 10;
         end else begin
            x = $urandom_range(0, 1) ? 32767 : -32768;
            y = $urandom_range(0, 1) ? 32767 : -32768;
         end
         row = mk(x, y, ($urandom_range(0, 4) == 0) || (n == count - 1));
         push_point(row);
         n++;
      end
   endtask

   initial begin
      point_row_type directed[$];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Degenerate segment at reset: projection is the origin.
      directed = {directed, mk_typed(3, 4, 3, 4, 25)};
      directed = {directed, mk_typed(-32768, -32768, -32768, -32768, 64'd2147483648)};
      directed = {directed, mk_typed(32767, 32767, 32767, 32767, 64'd2147352578)};
      directed = {directed, mk_typed(0, 0, 0, 0, 0)};
      directed = {directed, mk(10, 0, 1'b0)};
      directed = {directed, mk(5, 0, 1'b0)};
      directed = {directed, mk_typed(-5, 0, 5, 0, 25)};
      directed = {directed, mk(-32768, 32767, 1'b0)};
      directed = {directed, mk_typed(32767, -32768, -32768, 32767, 64'd2147418113)};
      foreach (directed[i]) push_point(directed[i]);
      req_push <= 1'b0;

      // Horizontal segment: before the start, beyond the end, inside.
      set_segment(0, 0, 100, 0);
      directed.delete();
      directed = {directed, mk(-50, 3, 1'b1)};
      directed = {directed, mk(200, -7, 1'b1)};
      directed = {directed, mk(40, 9, 1'b0)};
      directed = {directed, mk(41, -9, 1'b1)};
      foreach (directed[i]) push_point(directed[i]);
      req_push <= 1'b0;

      set_segment(0, 0, 3, 2);
      directed.delete();
      directed = {directed, mk(1, 3, 1'b1)};
      directed = {directed, mk(2, -1, 1'b0)};
      directed = {directed, mk(-2, 5, 1'b1)};
      foreach (directed[i]) push_point(directed[i]);
      random_sets(150, 0, 0, 3, 2);
      req_push <= 1'b0;

      set_segment(-32768, -32768, 32767, 32767);
      random_sets(200, -32768, -32768, 32767, 32767);
      req_push <= 1'b0;
      set_segment(32767, -32768, -32768, 32767);
      random_sets(200, 32767, -32768, -32768, 32767);
      req_push <= 1'b0;
      set_segment(1234, 1234, 1234, 1234);
      random_sets(100, 1234, 1234, 1234, 1234);
      req_push <= 1'b0;
      set_segment($signed(16'($urandom)), $signed(16'($urandom)),
                  $signed(16'($urandom)), $signed(16'($urandom)));
      random_sets(200, seg_sx, seg_sy, seg_ex, seg_ey);
      req_push <= 1'b0;
      set_segment(-300, 50, 700, -20);
      random_sets(150, -300, 50, 700, -20);
      req_push <= 1'b0;

      wait (expected_nearest.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("nearest_point_to_segment_search verification clean");
      end else begin
         $display("nearest_point_to_segment_search verification failed");
      end
      $finish;
   end

   // Result side: check each transfer, then choose the next pop level.
   initial begin
      int unsigned stall;
      nearest_type want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (expected_nearest.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: x=%0d y=%0d d=%0d",
                           rsp_nearest_x, rsp_nearest_y, rsp_nearest_dist_sq);
            end else begin
               want = expected_nearest.pop_front();
               if (want.x !== rsp_nearest_x || want.y !== rsp_nearest_y ||
                   want.dist_sq !== rsp_nearest_dist_sq) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected x=%0d y=%0d d=%0d, got x=%0d y=%0d d=%0d",
                              want.x, want.y, want.dist_sq,
                              rsp_nearest_x, rsp_nearest_y, rsp_nearest_dist_sq);
               end
            end
         end
         if (stall == 0) stall = pick_gap(quiet_pop);
         else stall--;
         rsp_pop <= (stall == 0);
      end
   end

   initial begin
      #20ms;
      $display("nearest_point_to_segment_search verification failed");
      $finish;
   end
endmodule
